### hdl/nsfp_pkg.sv
// Package: shared types, constants and field-map table for the NMEA sentence field parser.
`default_nettype none
package nsfp_pkg;

  localparam int DefSatSlots  = 16;
  localparam int DefMaxFields = 31;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [23:0] TAG_RMC = 24'h524D43;
  localparam logic [23:0] TAG_GSV = 24'h475356;
  localparam logic [23:0] TAG_GGA = 24'h474741;
  localparam logic [23:0] TAG_GSA = 24'h475341;
  localparam logic [23:0] TAG_VTG = 24'h565447;
  localparam logic [23:0] TAG_ZDA = 24'h5A4441;

  localparam logic [2:0] KIND_RMC = 3'd0;
  localparam logic [2:0] KIND_GSV = 3'd1;
  localparam logic [2:0] KIND_GGA = 3'd2;
  localparam logic [2:0] KIND_GSA = 3'd3;
  localparam logic [2:0] KIND_VTG = 3'd4;
  localparam logic [2:0] KIND_ZDA = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN = 3'd7;

  localparam logic [1:0] VK_INT  = 2'd0;
  localparam logic [1:0] VK_DEC  = 2'd1;
  localparam logic [1:0] VK_CHAR = 2'd2;

  localparam logic [7:0] NOMAP = 8'hFF;
  localparam logic [47:0] CAP47 = 48'h8000_0000_0000;

  // One finished field, as handed from the front to the back.
  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  field;
    logic [4:0]  target;
    logic [1:0]  vkind;
    logic        neg;
    logic [47:0] mant;
    logic [3:0]  frac;
    logic [7:0]  first;
    logic [7:0]  msg;
  } fld_t;

  // One result beat.
  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  field;
    logic [4:0]  target;
    logic [3:0]  slot;
    logic [1:0]  vkind;
    logic [47:0] number;
    logic [3:0]  frac;
    logic [7:0]  first;
  } res_t;

  // Field map entry: target + 32 * value kind, or NOMAP.
  function automatic logic [7:0] fmap(input logic [2:0] kind, input logic [5:0] fld);
    logic [7:0] e;
    e = NOMAP;
    if (fld != 6'd0 && fld < 6'd20) begin
      unique case (kind)
        KIND_RMC: begin
          case (fld)
            6'd1: e = 8'd32; 6'd2: e = 8'd65; 6'd3: e = 8'd34; 6'd4: e = 8'd67;
            6'd5: e = 8'd36; 6'd6: e = 8'd69; 6'd7: e = 8'd38; 6'd8: e = 8'd39;
            6'd9: e = 8'd8;  6'd12: e = 8'd73;
            default: e = NOMAP;
          endcase
        end
        KIND_GSV: begin
          if (fld <= 6'd3) e = 8'd10;
          else e = 8'd11 + {6'd0, fld[1:0]};
        end
        KIND_GGA: begin
          case (fld)
            6'd1: e = 8'd32; 6'd2: e = 8'd34; 6'd3: e = 8'd67; 6'd4: e = 8'd36;
            6'd5: e = 8'd69; 6'd6: e = 8'd15; 6'd7: e = 8'd10; 6'd8: e = 8'd48;
            6'd9: e = 8'd49; 6'd11: e = 8'd50; 6'd14: e = 8'd19;
            default: e = NOMAP;
          endcase
        end
        KIND_GSA: begin
          case (fld)
            6'd1: e = 8'd73; 6'd2: e = 8'd15; 6'd15: e = 8'd52; 6'd16: e = 8'd48;
            6'd17: e = 8'd53; 6'd18, 6'd19: e = NOMAP;
            default: e = 8'd11;
          endcase
        end
        KIND_VTG: begin
          case (fld)
            6'd1: e = 8'd54; 6'd3: e = 8'd39; 6'd5: e = 8'd38; 6'd7: e = 8'd55;
            6'd9: e = 8'd73;
            default: e = NOMAP;
          endcase
        end
        KIND_ZDA: begin
          case (fld)
            6'd1: e = 8'd32; 6'd2: e = 8'd24; 6'd3: e = 8'd25; 6'd4: e = 8'd26;
            6'd5: e = 8'd27; 6'd6: e = 8'd28;
            default: e = NOMAP;
          endcase
        end
        default: e = NOMAP;
      endcase
    end
    return e;
  endfunction

endpackage
`default_nettype wire

### hdl/nmea_sentence_field_parser.sv
// Top level of the NMEA sentence field parser.
`default_nettype none
// NMEA-0183 field parser. Push one character per beat on in_char_in; a result
// beat appears for each mapped, nonempty field when its ',' or '*' arrives
// (an out-of-range satellite slot is dropped). The block accepts one character
// every cycle while full is low. The front end updates its field state as each
// character is accepted, and a four-entry field queue plus an output register
// let the back end compute satellite slots and format values independently, so
// a stalled reader only stops input (full rises) once that queue fills. Each
// closed field goes into the queue, then the output register, until popped.
// There is no checksum check; the reset state is ready for a '$'.
module nmea_sentence_field_parser import nsfp_pkg::*; #(
  parameter int SAT_SLOTS  = DefSatSlots,
  parameter int MAX_FIELDS = DefMaxFields
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_char_in,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       out_sentence_kind,
  output logic [4:0]       out_field_number,
  output logic [4:0]       out_target,
  output logic [3:0]       out_sat_slot,
  output logic [1:0]       out_value_kind,
  output logic signed [47:0] out_number,
  output logic [3:0]       out_fraction_digits,
  output logic [7:0]       out_first_char
);

  fld_t fld;
  logic fld_vld, fld_full;
  res_t res;

  // The front only advances when the queue can take a possible field beat.
  nsfp_front #(.MAX_FIELDS(MAX_FIELDS)) u_front (
    .clk, .rst_n, .ch_vld(push && !full), .ch(in_char_in), .fld, .fld_vld);

  nsfp_back #(.SAT_SLOTS(SAT_SLOTS)) u_back (
    .clk, .rst_n, .fld_vld, .fld, .fld_full, .res, .res_empty(empty), .res_pop(pop));

  assign full                = fld_full;
  assign out_sentence_kind   = res.kind;
  assign out_field_number    = res.field;
  assign out_target          = res.target;
  assign out_sat_slot        = res.slot;
  assign out_value_kind      = res.vkind;
  assign out_number          = res.number;
  assign out_fraction_digits = res.frac;
  assign out_first_char      = res.first;

endmodule
`default_nettype wire

### hdl/nsfp_front.sv
// Front end: sentence framing, header detection and per-character number accumulation.
`default_nettype none
module nsfp_front import nsfp_pkg::*; #(
  parameter int MAX_FIELDS = DefMaxFields
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       ch_vld,
  input  wire logic [7:0] ch,
  output fld_t            fld,
  output logic            fld_vld
);

  logic        in_sent_r, in_sent_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [5:0]  fcnt_r, fcnt_nxt;
  logic [23:0] hwin_r, hwin_nxt;
  logic [5:0]  hits_r, hits_nxt;
  logic [47:0] mant_r, mant_nxt;
  logic [3:0]  frac_r, frac_nxt;
  logic        neg_r, neg_nxt, pt_r, pt_nxt, stop_r, stop_nxt, start_r, start_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  gsv_r, gsv_nxt;
  logic [7:0]  ent;
  logic        dec, is_dig, is_sep;
  logic [51:0] prod;
  logic [2:0]  kpick;

  assign ent    = fmap(kind_r, fcnt_r);
  assign dec    = (ent != NOMAP) && (ent[7:5] == 3'd1);
  assign is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_sep = (ch == CH_COMMA) || (ch == CH_STAR);
  assign prod   = {4'd0, mant_r} * 52'd10 + {48'd0, ch[3:0] - 4'd0};

  always_comb begin
    kpick = KIND_UNKNOWN;
    for (int k = 5; k >= 0; k--) if (hits_r[k]) kpick = 3'(k);
  end

  always_comb begin
    in_sent_nxt = in_sent_r; kind_nxt = kind_r; fcnt_nxt = fcnt_r;
    hwin_nxt = hwin_r; hits_nxt = hits_r; mant_nxt = mant_r; frac_nxt = frac_r;
    neg_nxt = neg_r; pt_nxt = pt_r; stop_nxt = stop_r; start_nxt = start_r;
    first_nxt = first_r; gsv_nxt = gsv_r;
    fld_vld = 1'b0;
    fld.kind = kind_r; fld.field = fcnt_r; fld.target = ent[4:0];
    fld.vkind = ent[6:5]; fld.neg = neg_r; fld.mant = mant_r; fld.frac = frac_r;
    fld.first = first_r; fld.msg = gsv_r;
    if (ch_vld && ch != 8'd0) begin
      if (ch == CH_DOLLAR) begin
        in_sent_nxt = 1'b1; kind_nxt = KIND_UNKNOWN; fcnt_nxt = '0;
        hwin_nxt = '0; hits_nxt = '0; gsv_nxt = '0;
        mant_nxt = '0; frac_nxt = '0; neg_nxt = 1'b0; pt_nxt = 1'b0;
        stop_nxt = 1'b0; start_nxt = 1'b0; first_nxt = '0;
      end else if (in_sent_r) begin
        if (is_sep) begin
          if (fcnt_r == '0) kind_nxt = kpick;
          else fld_vld = (ent != NOMAP) && (first_r != 8'd0);
          // The GSV message number is latched when its field closes.
          if (fld_vld && kind_r == KIND_GSV && fcnt_r == 6'd2)
            gsv_nxt = neg_r ? 8'd0 : ((mant_r > 48'd255) ? 8'd255 : mant_r[7:0]);
          if (ch == CH_STAR || fcnt_r >= 6'(MAX_FIELDS)) in_sent_nxt = 1'b0;
          else fcnt_nxt = fcnt_r + 6'd1;
          mant_nxt = '0; frac_nxt = '0; neg_nxt = 1'b0; pt_nxt = 1'b0;
          stop_nxt = 1'b0; start_nxt = 1'b0; first_nxt = '0;
        end else begin
          if (first_r == 8'd0) first_nxt = ch;
          if (fcnt_r == '0) begin
            hwin_nxt = {hwin_r[15:0], ch};
            hits_nxt = hits_r | {hwin_nxt == TAG_ZDA, hwin_nxt == TAG_VTG,
                                 hwin_nxt == TAG_GSA, hwin_nxt == TAG_GGA,
                                 hwin_nxt == TAG_GSV, hwin_nxt == TAG_RMC};
          end else if (!stop_r) begin
            if (!start_r && (ch == CH_SPACE || (ch >= 8'd9 && ch <= 8'd13))) begin
              // leading white space skipped
            end else if (!start_r && (ch == CH_PLUS || ch == CH_MINUS)) begin
              start_nxt = 1'b1;
              if (ch == CH_MINUS) neg_nxt = 1'b1;
            end else if (is_dig) begin
              start_nxt = 1'b1;
              if (mant_r < CAP47 && !(pt_r && frac_r == 4'd15)) begin
                mant_nxt = (prod > {4'd0, CAP47}) ? CAP47 : prod[47:0];
                if (pt_r) frac_nxt = frac_r + 4'd1;
              end
            end else if (ch == CH_POINT && dec && !pt_r) begin
              pt_nxt = 1'b1; start_nxt = 1'b1;
            end else begin
              stop_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sent_r <= 1'b0; kind_r <= KIND_UNKNOWN; fcnt_r <= '0; hwin_r <= '0;
      hits_r <= '0; mant_r <= '0; frac_r <= '0; neg_r <= 1'b0; pt_r <= 1'b0;
      stop_r <= 1'b0; start_r <= 1'b0; first_r <= '0; gsv_r <= '0;
    end else begin
      in_sent_r <= in_sent_nxt; kind_r <= kind_nxt; fcnt_r <= fcnt_nxt;
      hwin_r <= hwin_nxt; hits_r <= hits_nxt; mant_r <= mant_nxt;
      frac_r <= frac_nxt; neg_r <= neg_nxt; pt_r <= pt_nxt; stop_r <= stop_nxt;
      start_r <= start_nxt; first_r <= first_nxt; gsv_r <= gsv_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/nsfp_back.sv
// Back end: satellite slot computation, value formatting and result queue.
`default_nettype none
module nsfp_back import nsfp_pkg::*; #(
  parameter int SAT_SLOTS = DefSatSlots
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  fld_vld,
  input  fld_t       fld,
  output logic       fld_full,
  output res_t       res,
  output logic       res_empty,
  input  wire logic  res_pop
);

  localparam int QD = 4;
  fld_t        q_r [QD];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  cnt_r;
  res_t        out_r;
  logic        ov_r;
  fld_t        h;
  logic        take, drop, ok;
  logic [9:0]  slot;
  logic [7:0]  msg;
  logic        push;

  assign fld_full = (cnt_r == 3'(QD));
  assign h        = q_r[rp_r];
  assign push     = fld_vld && !fld_full;
  assign take     = (cnt_r != 3'd0) && (!ov_r || res_pop);

  always_comb begin
    msg  = h.msg;
    drop = 1'b0;
    slot = '0;
    if (h.target >= 5'd11 && h.target <= 5'd14) begin
      if (h.kind == KIND_GSV) begin
        slot = ({2'd0, msg} - 10'd1) * 10'd4 + 10'(({4'd0, h.field} - 10'd4) >> 2);
        if (msg == 8'd0) drop = 1'b1;
      end else begin
        slot = {4'd0, h.field} - 10'd3;
      end
      if (slot >= 10'(SAT_SLOTS)) drop = 1'b1;
    end
    ok = !drop;
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= fld;
    if (take && ok) begin
      out_r.kind   <= h.kind;
      out_r.field  <= h.field[4:0];
      out_r.target <= h.target;
      out_r.slot   <= slot[3:0];
      out_r.vkind  <= h.vkind;
      out_r.number <= (h.vkind == VK_CHAR) ? 48'd0 :
                      h.neg ? (48'd0 - h.mant) :
                      ((h.mant >= CAP47) ? CAP47 - 48'd1 : h.mant);
      out_r.frac   <= (h.vkind == VK_DEC) ? h.frac : 4'd0;
      out_r.first  <= (h.vkind == VK_CHAR) ? h.first : 8'd0;
    end
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (take) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(take);
      if (take) ov_r <= ok;
      else if (res_pop) ov_r <= 1'b0;
    end
  end

  assign res       = out_r;
  assign res_empty = !ov_r;

  // A result register never changes while it waits to be taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !res_pop |=> ov_r && $stable(out_r)) else $error("result changed");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(QD)) else $error("queue overflow");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> cnt_r != 3'd0) else $error("pop from empty queue");

endmodule
`default_nettype wire
